FILE: hdl/ple_pkg.sv
package ple_pkg;

  localparam int VALUE_W   = 32;
  localparam int POS_W     = 5;
  localparam int CNT_W     = 5;
  localparam int OP_W      = 3;
  localparam int STAT_W    = 3;
  localparam int CAPACITY_DEFAULT = 16;

  // request op codes
  localparam logic [OP_W-1:0] OP_INS_FRONT = 3'd0;
  localparam logic [OP_W-1:0] OP_INS_BACK  = 3'd1;
  localparam logic [OP_W-1:0] OP_INS_AT    = 3'd2;
  localparam logic [OP_W-1:0] OP_DEL_FRONT = 3'd3;
  localparam logic [OP_W-1:0] OP_DEL_BACK  = 3'd4;
  localparam logic [OP_W-1:0] OP_DEL_AT    = 3'd5;
  localparam logic [OP_W-1:0] OP_DUMP      = 3'd6;

  // result status codes
  localparam logic [STAT_W-1:0] STAT_OK         = 3'd0;
  localparam logic [STAT_W-1:0] STAT_FULL       = 3'd1;
  localparam logic [STAT_W-1:0] STAT_EMPTY      = 3'd2;
  localparam logic [STAT_W-1:0] STAT_BADPOS     = 3'd3;
  localparam logic [STAT_W-1:0] STAT_EMPTY_DUMP = 3'd4;

  typedef struct packed {
    logic [OP_W-1:0]           op;
    logic signed [VALUE_W-1:0] value;
    logic [POS_W-1:0]          position;
  } ple_in_t;

  typedef struct packed {
    logic signed [VALUE_W-1:0] item_value;
    logic [POS_W-1:0]          item_position;
    logic                      last;
    logic [STAT_W-1:0]         status;
    logic [CNT_W-1:0]          count;
  } ple_out_t;

  // what every cell does this cycle
  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_INS,   // open a gap at idx, shift right above it
    CELL_DEL,   // close the gap at idx, shift left from it
    CELL_ROT    // shift left, slot idx takes the old head
  } ple_cell_op_t;

  typedef struct packed {
    ple_cell_op_t              kind;
    logic [CNT_W-1:0]          idx;
    logic signed [VALUE_W-1:0] value;
  } ple_cell_cmd_t;

  typedef enum logic {
    STATE_IDLE,
    STATE_DUMP
  } ple_state_t;

endpackage

FILE: hdl/ple_cell.sv
module ple_cell #(
  parameter int INDEX = 0
) (
  input  logic                          clk,
  input  ple_pkg::ple_cell_cmd_t        cmd,
  input  logic signed [ple_pkg::VALUE_W-1:0] left,
  input  logic signed [ple_pkg::VALUE_W-1:0] right,
  input  logic signed [ple_pkg::VALUE_W-1:0] head,
  output logic signed [ple_pkg::VALUE_W-1:0] entry
);
  import ple_pkg::*;

  localparam logic [CNT_W-1:0] MY_IDX = CNT_W'(INDEX);

  logic signed [VALUE_W-1:0] entry_next;

  always_comb begin
    entry_next = entry;
    case (cmd.kind)
      CELL_INS: begin
        if (MY_IDX == cmd.idx) begin
          entry_next = cmd.value;
        end else if (MY_IDX > cmd.idx) begin
          entry_next = left;
        end
      end
      CELL_DEL: begin
        if (MY_IDX >= cmd.idx) begin
          entry_next = right;
        end
      end
      CELL_ROT: begin
        if (MY_IDX == cmd.idx) begin
          entry_next = head;
        end else if (MY_IDX < cmd.idx) begin
          entry_next = right;
        end
      end
      default: entry_next = entry;
    endcase
  end

  // payload only, no reset: slots are read only after being written
  always_ff @(posedge clk) begin
    entry <= entry_next;
  end

endmodule

FILE: hdl/positional_list_engine_top.sv
// Channel | Signals                        | Direction | Word
// cmd     | cmd_valid, cmd_ready, cmd      | in        | ple_in_t: op, value, position
// res     | res_valid, res_ready, res      | out       | ple_out_t: item_value, item_position,
//         |                                |           |   last, status, count
//
// Inserts, deletes and status-only ops complete on the accepting edge: the whole row of cells shifts at once
// and the status word lands in the output register on the same edge.
// A dump of N entries: the accepting edge loads no word, then one word per cycle while the
// output register is free; the row rotates left by one slot with each word so the head cell always
// holds the next entry, and after N steps it is restored.
// A new command is taken only in idle while the output register is empty or being drained.
// Reset (rst, synchronous) empties the list and the output register; cells keep stale data.
// A stalled res_ready freezes the dump in place; nothing is lost or repeated.
module positional_list_engine_top #(
  parameter int CAPACITY = ple_pkg::CAPACITY_DEFAULT
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cmd_valid,
  output logic              cmd_ready,
  input  ple_pkg::ple_in_t  cmd,
  output logic              res_valid,
  input  logic              res_ready,
  output ple_pkg::ple_out_t res
);
  import ple_pkg::*;

  localparam logic [CNT_W:0] CAP_EXT = (CNT_W + 1)'(CAPACITY);

  ple_state_t       state, state_next;
  logic [CNT_W-1:0] count, count_next;
  logic [CNT_W-1:0] dump_pos;
  logic [CNT_W-1:0] last_idx;
  ple_out_t         res_new;
  ple_cell_cmd_t    cell_cmd;
  logic             slot_free;
  logic             accept;
  logic             load;
  logic             dump_start;
  logic             dump_last;

  logic signed [VALUE_W-1:0] entries [CAPACITY];

  assign slot_free = !res_valid || res_ready;
  assign cmd_ready = (state == STATE_IDLE) && slot_free;
  assign accept    = cmd_valid && cmd_ready;
  assign last_idx  = count - CNT_W'(1);
  assign dump_last = (dump_pos == last_idx);

  // ---- row of cells: each slot talks to its neighbors and sees the head ----
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic signed [VALUE_W-1:0] left_val;
    logic signed [VALUE_W-1:0] right_val;
    if (i == 0) begin : g_first
      assign left_val = '0;
    end else begin : g_mid_l
      assign left_val = entries[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign right_val = '0;
    end else begin : g_mid_r
      assign right_val = entries[i+1];
    end
    ple_cell #(.INDEX(i)) u_cell (
      .clk   (clk),
      .cmd   (cell_cmd),
      .left  (left_val),
      .right (right_val),
      .head  (entries[0]),
      .entry (entries[i])
    );
  end

  // ---- command decode and output word ----
  always_comb begin
    logic [STAT_W-1:0] status;
    logic [CNT_W:0]    pos_ext;
    logic [CNT_W:0]    cnt_ext;
    status        = STAT_OK;
    pos_ext       = {1'b0, cmd.position};
    cnt_ext       = {1'b0, count};
    cell_cmd.kind  = CELL_HOLD;
    cell_cmd.idx   = '0;
    cell_cmd.value = cmd.value;
    count_next    = count;
    load          = 1'b0;
    dump_start    = 1'b0;
    res_new       = '0;

    if (accept) begin
      case (cmd.op)
        OP_INS_FRONT, OP_INS_BACK, OP_INS_AT: begin
          if (cnt_ext >= CAP_EXT) begin
            status = STAT_FULL;
          end else if (cmd.op == OP_INS_FRONT) begin
            cell_cmd.kind = CELL_INS;
            cell_cmd.idx  = '0;
          end else if (cmd.op == OP_INS_BACK) begin
            cell_cmd.kind = CELL_INS;
            cell_cmd.idx  = count;
          end else if (cmd.position == '0 || pos_ext > cnt_ext + (CNT_W + 1)'(1)) begin
            status = STAT_BADPOS;
          end else begin
            cell_cmd.kind = CELL_INS;
            cell_cmd.idx  = cmd.position - CNT_W'(1);
          end
          if (cell_cmd.kind == CELL_INS) begin
            count_next = count + CNT_W'(1);
          end
        end
        OP_DEL_FRONT, OP_DEL_BACK, OP_DEL_AT: begin
          if (count == '0) begin
            status = STAT_EMPTY;
          end else if (cmd.op == OP_DEL_FRONT) begin
            cell_cmd.kind = CELL_DEL;
            cell_cmd.idx  = '0;
          end else if (cmd.op == OP_DEL_BACK) begin
            cell_cmd.kind = CELL_DEL;
            cell_cmd.idx  = last_idx;
          end else if (cmd.position == '0 || pos_ext > cnt_ext) begin
            status = STAT_BADPOS;
          end else begin
            cell_cmd.kind = CELL_DEL;
            cell_cmd.idx  = cmd.position - CNT_W'(1);
          end
          if (cell_cmd.kind == CELL_DEL) begin
            count_next = count - CNT_W'(1);
          end
        end
        OP_DUMP: begin
          if (count == '0) begin
            status = STAT_EMPTY_DUMP;
          end else begin
            dump_start = 1'b1;
          end
        end
        default: status = STAT_OK;
      endcase
      if (!dump_start) begin
        load           = 1'b1;
        res_new.last   = 1'b1;
        res_new.status = status;
        res_new.count  = count_next;
      end
    end else if (state == STATE_DUMP && slot_free) begin
      // head cell holds the next entry; rotate it to the tail of the list
      load                  = 1'b1;
      res_new.item_value    = entries[0];
      res_new.item_position = dump_pos + CNT_W'(1);
      res_new.last          = dump_last;
      res_new.status        = STAT_OK;
      res_new.count         = count;
      cell_cmd.kind         = CELL_ROT;
      cell_cmd.idx          = last_idx;
    end
  end

  // ---- next state ----
  always_comb begin
    state_next = state;
    case (state)
      STATE_IDLE: begin
        if (dump_start) begin
          state_next = STATE_DUMP;
        end
      end
      STATE_DUMP: begin
        if (slot_free && dump_last) begin
          state_next = STATE_IDLE;
        end
      end
      default: state_next = STATE_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= STATE_IDLE;
      count     <= '0;
      dump_pos  <= '0;
      res_valid <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      if (dump_start) begin
        dump_pos <= '0;
      end else if (state == STATE_DUMP && slot_free) begin
        dump_pos <= dump_pos + CNT_W'(1);
      end
      if (load) begin
        res_valid <= 1'b1;
      end else if (res_ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res <= res_new;
    end
  end

endmodule

FILE: tb/tb.sv
`timescale 1ns / 1ps

// Testbench for positional_list_engine_top.
//
// A behavioral copy of the list (array plus length) sits in the testbench. Each command word
// that the block accepts is applied to that copy, and the words the block should return are
// queued. A checker process pops the queue for every result word the block hands over and
// compares the words field by field.
//
// Handshakes are sampled at the falling edge. Everything the testbench drives changes only
// at the rising edge, so the value seen at negedge is the value the next rising edge acts on.
//
// Test order: directed corner cases, random traffic, a long receiver stall while the sender
// keeps pushing inserts into a full list, then more random traffic. The idle mix changes
// between phases: sender 31% / receiver 48%, then 48% / 31%, then no idling at all.
module tb;
  import ple_pkg::*;

  localparam int LIST_CAP = CAPACITY_DEFAULT;
  localparam logic [OP_W-1:0] OP_SPARE = 3'd7;  // unused code, status only
  localparam int STALL_CYCLES = 300;

  logic     clk;
  logic     rst;
  logic     cmd_valid;
  logic     cmd_ready;
  ple_in_t  cmd;
  logic     res_valid;
  logic     res_ready;
  ple_out_t res;

  positional_list_engine_top #(
    .CAPACITY(LIST_CAP)
  ) uut (
    .clk      (clk),
    .rst      (rst),
    .cmd_valid(cmd_valid),
    .cmd_ready(cmd_ready),
    .cmd      (cmd),
    .res_valid(res_valid),
    .res_ready(res_ready),
    .res      (res)
  );

  // shadow copy of the list
  logic signed [VALUE_W-1:0] shadow_vals [LIST_CAP];
  int                        shadow_len;

  // result words still owed by the block, oldest first
  ple_out_t pending_words[$];

  int  mismatch_cnt;
  int  tx_idle_pct;
  int  rx_idle_pct;
  bit  stall_req;   // receiver holds off while set
  bit  filling;     // random traffic leans toward inserts while set

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("FAILED: results differ");
    $finish;
  end

  // ---------------------------------------------------------------------------------------
  // Predictor: apply one command word to the shadow list, queue the expected result words.
  // ---------------------------------------------------------------------------------------
  function automatic ple_out_t status_word(logic [STAT_W-1:0] st);
    ple_out_t w;
    w = '0;
    w.last   = 1'b1;
    w.status = st;
    w.count  = CNT_W'(shadow_len);
    return w;
  endfunction

  task automatic apply_list_op(input ple_in_t w);
    logic [STAT_W-1:0] st;
    int                slot;
    ple_out_t          rw;
    st   = STAT_OK;
    slot = -1;
    case (w.op)
      OP_INS_FRONT, OP_INS_BACK, OP_INS_AT: begin
        // full wins over a bad position
        if (shadow_len >= LIST_CAP) st = STAT_FULL;
        else if (w.op == OP_INS_FRONT) slot = 0;
        else if (w.op == OP_INS_BACK) slot = shadow_len;  // empty list: same as front
        else if (w.position < 1 || w.position > shadow_len + 1) st = STAT_BADPOS;
        else slot = w.position - 1;
        if (slot >= 0) begin
          for (int i = shadow_len; i > slot; i--) shadow_vals[i] = shadow_vals[i-1];
          shadow_vals[slot] = w.value;
          shadow_len++;
        end
      end
      OP_DEL_FRONT, OP_DEL_BACK, OP_DEL_AT: begin
        // empty wins over a bad position
        if (shadow_len == 0) st = STAT_EMPTY;
        else if (w.op == OP_DEL_FRONT) slot = 0;
        else if (w.op == OP_DEL_BACK) slot = shadow_len - 1;
        else if (w.position < 1 || w.position > shadow_len) st = STAT_BADPOS;
        else slot = w.position - 1;
        if (slot >= 0) begin
          for (int i = slot; i + 1 < shadow_len; i++) shadow_vals[i] = shadow_vals[i+1];
          shadow_len--;
        end
      end
      OP_DUMP: begin
        if (shadow_len == 0) begin
          st = STAT_EMPTY_DUMP;
        end else begin
          for (int i = 0; i < shadow_len; i++) begin
            rw               = '0;
            rw.item_value    = shadow_vals[i];
            rw.item_position = POS_W'(i + 1);
            rw.last          = (i + 1 == shadow_len);
            rw.status        = STAT_OK;
            rw.count         = CNT_W'(shadow_len);
            pending_words.push_back(rw);
          end
          return;
        end
      end
      default: ;  // spare code: no change, plain ok status
    endcase
    pending_words.push_back(status_word(st));
  endtask

  // ---------------------------------------------------------------------------------------
  // Mismatch reporting and result checking
  // ---------------------------------------------------------------------------------------
  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("%0t ns: mismatch on %s: got %0d, want %0d", $time, what, got, want);
    mismatch_cnt++;
  endtask

  always @(negedge clk) begin
    ple_out_t want;
    if (!rst && res_valid && res_ready) begin
      if (pending_words.size() == 0) begin
        report_mismatch("unexpected word, status", res.status, -1);
      end else begin
        want = pending_words.pop_front();
        if (res.item_value !== want.item_value)
          report_mismatch("item_value", res.item_value, want.item_value);
        if (res.item_position !== want.item_position)
          report_mismatch("item_position", res.item_position, want.item_position);
        if (res.last !== want.last)
          report_mismatch("last", res.last, want.last);
        if (res.status !== want.status)
          report_mismatch("status", res.status, want.status);
        if (res.count !== want.count)
          report_mismatch("count", res.count, want.count);
      end
    end
  end

  // Receiver: random backpressure, or a solid hold-off while stall_req is set.
  always @(posedge clk) begin
    if (stall_req) res_ready <= 1'b0;
    else res_ready <= ($urandom_range(0, 99) >= rx_idle_pct);
  end

  // Long hold-off, counted here so the sender can keep offering words meanwhile.
  initial begin
    forever begin
      wait (stall_req);
      repeat (STALL_CYCLES) @(posedge clk);
      stall_req = 1'b0;
    end
  end

  // ---------------------------------------------------------------------------------------
  // Sender: offer one word, optionally after idle cycles, and wait until it is taken.
  // Called right after a rising edge; returns right after the edge that took the word.
  // ---------------------------------------------------------------------------------------
  task automatic send_word(input logic [OP_W-1:0] op, input logic signed [VALUE_W-1:0] value,
                           input logic [POS_W-1:0] position);
    ple_in_t w;
    bit      taken;
    w.op       = op;
    w.value    = value;
    w.position = position;
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      cmd_valid <= 1'b0;
      @(posedge clk);
    end
    cmd_valid <= 1'b1;
    cmd       <= w;
    do begin
      @(negedge clk);
      taken = cmd_ready;
      @(posedge clk);
    end while (!taken);
    apply_list_op(w);
  endtask

  function automatic logic signed [VALUE_W-1:0] pick_value();
    case ($urandom_range(0, 19))
      0:       return 32'sh7FFF_FFFF;
      1:       return 32'sh8000_0000;
      2:       return '0;
      3:       return -32'sd1;
      default: return $urandom;
    endcase
  endfunction

  // ---------------------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------------------
  task automatic test_directed();
    send_word(OP_DUMP,      32'sd5, 5'd3);   // empty dump
    send_word(OP_DEL_FRONT, 32'sd0, 5'd0);   // delete from empty
    send_word(OP_DEL_BACK,  32'sd0, 5'd0);
    send_word(OP_DEL_AT,    32'sd0, 5'd9);   // empty beats bad position
    send_word(OP_INS_BACK,  32'sh7FFF_FFFF, 5'd0);  // back of empty list = front
    send_word(OP_INS_FRONT, 32'sh8000_0000, 5'd0);
    send_word(OP_INS_AT,    32'sd11, 5'd0);  // position zero
    send_word(OP_INS_AT,    32'sd12, 5'd4);  // one past count + 1
    send_word(OP_INS_AT,    -32'sd1, 5'd2);  // middle
    send_word(OP_INS_AT,    32'sd0, 5'd4);   // exactly count + 1
    send_word(OP_INS_AT,    32'sd77, 5'd31);
    send_word(OP_DUMP,      32'sd0, 5'd0);
    send_word(OP_DEL_AT,    32'sd0, 5'd0);   // position zero
    send_word(OP_DEL_AT,    32'sd0, 5'd5);   // past count
    send_word(OP_DEL_AT,    32'sd0, 5'd31);
    send_word(OP_DEL_AT,    32'sd0, 5'd2);
    send_word(OP_DUMP,      32'sd0, 5'd0);
    send_word(OP_DEL_BACK,  32'sd0, 5'd0);
    send_word(OP_DEL_FRONT, 32'sd0, 5'd0);
    send_word(OP_DEL_AT,    32'sd0, 5'd1);   // only entry goes, list empties
    send_word(OP_DUMP,      32'sd0, 5'd0);
    send_word(OP_SPARE,     -32'sd1, 5'd31); // spare op code
    send_word(OP_INS_AT,    32'sh5A5A_A5A5, 5'd1);
    send_word(OP_SPARE,     32'sd0, 5'd0);
  endtask

  // Fill past capacity while the receiver is held off, so the block backs up into the
  // command channel; then dump the full list, delete its last entry by position and dump again.
  task automatic test_fill_under_stall();
    stall_req = 1'b1;
    for (int i = 0; i < LIST_CAP + 3; i++) begin
      if (i % 3 == 0) send_word(OP_INS_FRONT, pick_value(), 5'd0);
      else if (i % 3 == 1) send_word(OP_INS_BACK, pick_value(), 5'd0);
      else send_word(OP_INS_AT, pick_value(), POS_W'($urandom_range(1, shadow_len + 1)));
    end
    send_word(OP_INS_AT, 32'sd1, 5'd1);      // full beats position check
    send_word(OP_INS_AT, 32'sd1, 5'd31);
    send_word(OP_DUMP, 32'sd0, 5'd0);
    send_word(OP_DEL_AT, 32'sd0, 5'd16);
    send_word(OP_DEL_AT, 32'sd0, 5'd16);     // now past count
    send_word(OP_DUMP, 32'sd0, 5'd0);
  endtask

  // Random traffic that swings between filling and draining so both ends get reached.
  task automatic test_random(input int n_words);
    logic [OP_W-1:0]  op;
    logic [POS_W-1:0] pos;
    int               r;
    for (int k = 0; k < n_words; k++) begin
      if (shadow_len == LIST_CAP) filling = 1'b0;
      else if (shadow_len == 0) filling = 1'b1;
      else if ($urandom_range(0, 99) < 3) filling = !filling;
      r = $urandom_range(0, 99);
      if (r < 2) op = OP_SPARE;
      else if (r < 14) op = OP_DUMP;
      else if ($urandom_range(0, 99) < (filling ? 70 : 30))
        op = OP_INS_FRONT + OP_W'($urandom_range(0, 2));
      else
        op = OP_DEL_FRONT + OP_W'($urandom_range(0, 2));
      // mostly legal positions, some anywhere in the field
      if ($urandom_range(0, 99) < 20) pos = POS_W'($urandom_range(0, 31));
      else if (op == OP_INS_AT) pos = POS_W'($urandom_range(1, shadow_len + 1));
      else pos = POS_W'($urandom_range(1, (shadow_len > 0) ? shadow_len : 1));
      send_word(op, pick_value(), pos);
    end
  endtask

  initial begin
    rst          = 1'b1;
    cmd_valid    = 1'b0;
    cmd          = '0;
    res_ready    = 1'b0;
    shadow_len   = 0;
    mismatch_cnt = 0;
    stall_req    = 1'b0;
    filling      = 1'b1;
    tx_idle_pct  = 31;
    rx_idle_pct  = 48;
    for (int i = 0; i < LIST_CAP; i++) shadow_vals[i] = '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed();
    test_random(100);

    tx_idle_pct = 48;
    rx_idle_pct = 31;
    test_fill_under_stall();
    test_random(100);

    tx_idle_pct = 0;
    rx_idle_pct = 0;
    test_random(100);

    cmd_valid <= 1'b0;
    while (pending_words.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);  // catch any stray trailing words

    if (mismatch_cnt == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
